>>> src/ptsc_pkg.sv
// Shared types and constants for the period to spectrum color block.
package ptsc_pkg;
	localparam int POS_MAX = 762;
	localparam int BAND = 254;
	localparam int BAND2 = 508;
	localparam int BAND3 = 635;
	localparam int GATE_LO_HZ = 39;
	localparam int GATE_HI_HZ = 6000;
	localparam int BOUND_W = 13;
	localparam int PERIOD_W = 16;
	localparam int POS_W = 10;
	localparam int COLOR_W = 8;

	// Register indexes
	localparam logic REG_LOWER = 1'b0;
	localparam logic REG_UPPER = 1'b1;

	// Front end request into the divider queue
	typedef struct packed {
		logic signed [47:0] num;
		logic [29:0] den_mag;
		logic den_neg;
		logic eq;
	} div_req_t;
endpackage

>>> src/period_to_spectrum_color.sv
// Top level: period gate, divider pipeline and color output.
// A request passes the front end register, the two-entry queue, the divider stages and the output register.
// Throughput: one request per cycle unless out_ready holds the output; the divider is pipelined.
// Periods outside the gate produce no result.
// Reset (arst_n low, asynchronous) clears valids and sets both bounds to 0.
module period_to_spectrum_color #(
	parameter int TICK_RATE = 38462
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [15:0] period,
	input logic cfg_we,
	input logic cfg_index,
	input logic [12:0] cfg_data,
	output logic out_valid,
	input logic out_ready,
	output logic [9:0] position,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);
	logic [12:0] lower_q, upper_q;
	logic f_valid, f_ready, b_valid, b_ready;
	ptsc_pkg::div_req_t f_req, b_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptsc_pkg::REG_LOWER: lower_q <= cfg_data;
				ptsc_pkg::REG_UPPER: upper_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ptsc_front #(.TICK_RATE(TICK_RATE)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .period,
		.lower_bound(lower_q), .upper_bound(upper_q),
		.req_valid(f_valid), .req_ready(f_ready), .req(f_req)
	);

	ptsc_queue u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_req),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_req)
	);

	ptsc_back u_back (
		.clk, .arst_n, .req_valid(b_valid), .req_ready(b_ready), .req(b_req),
		.out_valid, .out_ready, .position, .red, .green, .blue
	);
endmodule

>>> src/ptsc_front.sv
// Front end: gate the period and form numerator and denominator.
module ptsc_front #(
	parameter int TICK_RATE = 38462
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [ptsc_pkg::PERIOD_W-1:0] period,
	input logic [ptsc_pkg::BOUND_W-1:0] lower_bound,
	input logic [ptsc_pkg::BOUND_W-1:0] upper_bound,
	output logic req_valid,
	input logic req_ready,
	output ptsc_pkg::div_req_t req
);
	localparam logic [39:0] RATE = 40'(TICK_RATE);

	logic [39:0] lo39, hi6k;
	logic pass;
	logic signed [31:0] lp, diffb;
	logic signed [47:0] num_c;
	logic signed [47:0] den_c;
	logic valid_s1;
	logic [ptsc_pkg::PERIOD_W-1:0] period_s1;
	logic signed [14:0] diff_s1;
	logic signed [31:0] top_s1;

	assign in_ready = !valid_s1 || req_ready;

	// Gate check
	assign lo39 = 40'(period) * 40'(ptsc_pkg::GATE_LO_HZ);
	assign hi6k = 40'(period) * 40'(ptsc_pkg::GATE_HI_HZ);
	assign pass = (RATE > lo39) && (RATE < hi6k);
	assign lp = 32'(lower_bound) * 32'(period);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && pass;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			period_s1 <= period;
			diff_s1 <= $signed({2'b0, upper_bound}) - $signed({2'b0, lower_bound});
			top_s1 <= $signed(32'(TICK_RATE)) - lp;
		end
	end

	// Second multiply stage
	assign diffb = 32'(diff_s1);
	assign num_c = 48'(top_s1) * 48'sd762;
	assign den_c = 48'($signed({1'b0, period_s1})) * 48'(diffb);

	assign req_valid = valid_s1;
	always_comb begin
		req.num = num_c;
		req.den_neg = den_c[47];
		req.den_mag = den_c[47] ? 30'(-den_c) : 30'(den_c);
		req.eq = (diff_s1 == 15'sd0);
	end
endmodule

>>> src/ptsc_queue.sv
// Two-entry queue between front and back.
module ptsc_queue (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input ptsc_pkg::div_req_t wr_data,
	output logic rd_valid,
	input logic rd_ready,
	output ptsc_pkg::div_req_t rd_data
);
	ptsc_pkg::div_req_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule

>>> src/ptsc_back.sv
// Back end: pipelined restoring divider, clamp and color mapping.
module ptsc_back (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input ptsc_pkg::div_req_t req,
	output logic out_valid,
	input logic out_ready,
	output logic [ptsc_pkg::POS_W-1:0] position,
	output logic [ptsc_pkg::COLOR_W-1:0] red,
	output logic [ptsc_pkg::COLOR_W-1:0] green,
	output logic [ptsc_pkg::COLOR_W-1:0] blue
);
	// Only the low quotient bits matter once clamped: quotient >= 2048 is overflow.
	// Magnitude of numerator <= ~2^39; we compute 11 quotient bits plus overflow.
	localparam int QB = 11;
	localparam int NW = 47;

	logic stall;
	logic [QB:0] v_q;
	logic [NW-1:0] rem_q [QB+1];
	logic [29:0] den_q [QB+1];
	logic [QB-1:0] quo_q [QB+1];
	logic ovf_q [QB+1];
	logic neg_q [QB+1];
	logic eq_q [QB+1];

	logic [46:0] nmag;
	logic [46:0] hi_part;
	logic valid_o_q;

	assign stall = valid_o_q && !out_ready;
	assign req_ready = !stall;
	assign nmag = req.num[47] ? 47'(-req.num) : 47'(req.num);
	assign hi_part = nmag >> QB;

	// Stage 0: overflow when numerator >= den << QB
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (!stall) begin
			v_q <= {v_q[QB-1:0], req_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			rem_q[0] <= nmag;
			den_q[0] <= req.den_mag;
			quo_q[0] <= '0;
			ovf_q[0] <= hi_part >= 47'(req.den_mag);
			neg_q[0] <= req.num[47] ^ req.den_neg;
			eq_q[0] <= req.eq;
		end
	end

	// One quotient bit per stage, msb first
	for (genvar i = 0; i < QB; i++) begin : g_div
		localparam int SH = QB - 1 - i;
		logic [NW-1:0] trial;
		logic take;
		assign trial = NW'(den_q[i]) << SH;
		assign take = !ovf_q[i] && (rem_q[i] >= trial);
		always_ff @(posedge clk) begin
			if (!stall) begin
				rem_q[i+1] <= take ? rem_q[i] - trial : rem_q[i];
				den_q[i+1] <= den_q[i];
				quo_q[i+1] <= quo_q[i] | (QB'(take) << SH);
				ovf_q[i+1] <= ovf_q[i];
				neg_q[i+1] <= neg_q[i];
				eq_q[i+1] <= eq_q[i];
			end
		end
	end

	// Clamp: a negative quotient or equal bounds give 0; overflow or a quotient above POS_MAX gives POS_MAX
	logic [ptsc_pkg::POS_W-1:0] pos;
	logic [ptsc_pkg::POS_W-1:0] m;
	always_comb begin
		priority if (eq_q[QB] || neg_q[QB]) begin
			pos = '0;
		end else if (ovf_q[QB] || quo_q[QB] > QB'(ptsc_pkg::POS_MAX)) begin
			pos = ptsc_pkg::POS_W'(ptsc_pkg::POS_MAX);
		end else begin
			pos = ptsc_pkg::POS_W'(quo_q[QB]);
		end
		// position mod 254; the top end wraps to zero
		priority if (pos >= 10'(ptsc_pkg::POS_MAX)) m = '0;
		else if (pos >= 10'(ptsc_pkg::BAND2)) m = pos - 10'(ptsc_pkg::BAND2);
		else if (pos >= 10'(ptsc_pkg::BAND)) m = pos - 10'(ptsc_pkg::BAND);
		else m = pos;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o_q <= 1'b0;
		end else if (!stall) begin
			valid_o_q <= v_q[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			position <= pos;
			priority if (pos < 10'(ptsc_pkg::BAND)) begin
				red <= 8'(10'(ptsc_pkg::BAND) - pos);
				green <= '0;
				blue <= 8'(pos);
			end else if (pos < 10'(ptsc_pkg::BAND2)) begin
				red <= '0;
				green <= 8'(m);
				blue <= 8'(10'(ptsc_pkg::BAND) - m);
			end else if (pos < 10'(ptsc_pkg::BAND3)) begin
				red <= 8'(m);
				green <= 8'(10'(ptsc_pkg::BAND) - m);
				blue <= 8'(m >> 1);
			end else begin
				red <= 8'(m);
				green <= 8'(m);
				blue <= 8'(m);
			end
		end
	end

	assign out_valid = valid_o_q;
endmodule

>>> src/ptsc_checker.sv
// Port-level checker for period_to_spectrum_color.
module ptsc_props (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [9:0] position,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue
);
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> position <= 10'd762) else $error("position out of range");
	a_band0: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && position < 10'd254) |->
		(green == 8'd0 && 10'(red) + position == 10'd254))
		else $error("band 0 color");
	a_band1: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && position >= 10'd254 && position < 10'd508) |->
		(red == 8'd0 && 9'(green) + 9'(blue) == 9'd254)) else $error("band 1 color");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(position)))
		else $error("result dropped under stall");
endmodule

bind period_to_spectrum_color ptsc_props u_ptsc_props (
	.clk, .arst_n, .out_valid, .out_ready, .position, .red, .green, .blue
);
